/* rtl/core/atl_pkg.sv */
// Shared types and constants for the arithmetic token lexer.
`timescale 1ns / 1ps
`default_nettype none

package atl_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_NUM   = 2'd1,
      MODE_IDENT = 2'd2,
      MODE_HALT  = 2'd3
   } scan_mode_type;

   typedef enum logic [3:0] {
      TOK_VAR     = 4'd0,
      TOK_ID      = 4'd1,
      TOK_EQ      = 4'd2,
      TOK_PLUS    = 4'd3,
      TOK_MINUS   = 4'd4,
      TOK_STAR    = 4'd5,
      TOK_SLASH   = 4'd6,
      TOK_LPAREN  = 4'd7,
      TOK_RPAREN  = 4'd8,
      TOK_ENDLINE = 4'd9,
      TOK_EOF     = 4'd10,
      TOK_NUMBER  = 4'd11,
      TOK_ERROR   = 4'd12
   } token_kind_type;

   localparam int NUM_W   = 63;
   localparam int CHARS_W = 64;
   localparam int LEN_W   = 4;
   localparam int POS_W   = 32;
   localparam int DATA_W  = 168;

   // Bit offsets of the result fields inside rsp_tdata.
   localparam int NUM_LSB   = 0;
   localparam int CHARS_LSB = NUM_LSB + NUM_W;
   localparam int LEN_LSB   = CHARS_LSB + CHARS_W;
   localparam int POS_LSB   = LEN_LSB + LEN_W;
   localparam int PAD_W     = DATA_W - POS_LSB - POS_W;

   localparam logic [NUM_W-1:0]   NUM_MAX = {NUM_W{1'b1}};
   localparam logic [CHARS_W-1:0] KW_VAR_PACKED = 64'h0000_0000_0072_6176;

   localparam logic [7:0] CHAR_EOT   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef struct packed {
      token_kind_type     kind;
      logic [NUM_W-1:0]   number;
      logic [CHARS_W-1:0] chars;
      logic [LEN_W-1:0]   length;
      logic [POS_W-1:0]   position;
      logic               last;
   } tok_type;

endpackage

`default_nettype wire

/* rtl/core/arith_token_lexer.sv */
// Character-at-a-time tokenizer for a small arithmetic language.
//
// Usage: one text byte per req beat (req_tdata[7:0]); a byte of zero ends the
// text and gives an Eof token, after which positions count from zero again.
// Each req beat gives zero, one or two rsp beats; rsp_tlast marks the last
// beat caused by a given req beat, rsp_tuser carries the token kind.
// Tokens of a byte are written into the result queue and reach rsp from there.
// Throughput: one byte per cycle. Bytes are scanned combinationally at the
// req port and their tokens go into a four-entry result queue; req_tready
// drops only while fewer than two queue entries are free, so a receiver that
// stalls fills the queue and then holds off the sender without losing beats.
// Decimal numbers saturate at 2^63-1; identifiers longer than
// MAX_IDENT_CHARS letters, or any invalid byte, give an error token and the
// lexer then swallows all further bytes without output until reset.
// Reset (synchronous) empties the queue and returns the scanner to idle at
// position zero; it takes effect in the cycle after it is asserted.
`timescale 1ns / 1ps
`default_nettype none

module arith_token_lexer #(
   parameter int MAX_IDENT_CHARS = 8
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // [7:0] char_code
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [167:0] rsp_tdata,   // [62:0] number_value, [126:63] ident_chars,
                                     // [130:127] ident_length,
                                     // [162:131] error_position, [167:163] zero
   output logic [3:0]   rsp_tuser,   // [3:0] token_kind
   output logic         rsp_tlast    // last_of_run
);

   localparam logic [atl_pkg::LEN_W-1:0] IDENT_LIMIT = atl_pkg::LEN_W'(MAX_IDENT_CHARS);

   // Scanner state.
   atl_pkg::scan_mode_type             mode_ff, mode_in;
   logic [atl_pkg::NUM_W-1:0]          acc_ff, acc_in;
   logic [atl_pkg::CHARS_W-1:0]        buf_ff, buf_in;
   logic [atl_pkg::LEN_W-1:0]          cnt_ff, cnt_in;
   logic [atl_pkg::POS_W-1:0]          pos_ff, pos_in;

   // Result queue.
   atl_pkg::tok_type                   queue_ff [4];
   logic [1:0]                         wr_ptr_ff, wr_ptr_in;
   logic [1:0]                         rd_ptr_ff, rd_ptr_in;
   logic [2:0]                         count_ff, count_in;

   logic                               req_fire;
   logic                               rsp_fire;
   logic [1:0]                         n_wr;
   atl_pkg::tok_type                   tok0, tok1;
   atl_pkg::tok_type                   head;

   function automatic atl_pkg::tok_type make_tok(
      input atl_pkg::token_kind_type kind,
      input logic [atl_pkg::NUM_W-1:0] number,
      input logic [atl_pkg::CHARS_W-1:0] chars,
      input logic [atl_pkg::LEN_W-1:0] length,
      input logic [atl_pkg::POS_W-1:0] position
   );
      atl_pkg::tok_type t;
      t.kind     = kind;
      t.number   = number;
      t.chars    = chars;
      t.length   = length;
      t.position = position;
      t.last     = 1'b0;
      return t;
   endfunction

   assign req_tready = (count_ff <= 3'd2);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Scan one byte: next state and up to two tokens.
   always_comb begin
      logic [7:0]  c;
      logic        is_digit, is_letter, is_single, flush, own;
      logic [3:0]  digit;
      logic [66:0] prod;
      atl_pkg::token_kind_type single_kind;
      atl_pkg::tok_type        pend_tok, own_tok;

      c         = req_tdata;
      digit     = 4'(c - atl_pkg::CHAR_ZERO);
      is_digit  = (c >= 8'h30) && (c <= 8'h39);
      is_letter = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));

      is_single   = 1'b1;
      single_kind = atl_pkg::TOK_EQ;
      case (c)
         8'h3d:   single_kind = atl_pkg::TOK_EQ;
         8'h2b:   single_kind = atl_pkg::TOK_PLUS;
         8'h2d:   single_kind = atl_pkg::TOK_MINUS;
         8'h2a:   single_kind = atl_pkg::TOK_STAR;
         8'h2f:   single_kind = atl_pkg::TOK_SLASH;
         8'h28:   single_kind = atl_pkg::TOK_LPAREN;
         8'h29:   single_kind = atl_pkg::TOK_RPAREN;
         8'h0a:   single_kind = atl_pkg::TOK_ENDLINE;
         default: is_single = 1'b0;
      endcase

      // acc * 10 + digit; anything past 63 bits saturates.
      prod = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + 67'(digit);

      // Token for whatever is pending.
      if (mode_ff == atl_pkg::MODE_NUM) begin
         pend_tok = make_tok(atl_pkg::TOK_NUMBER, acc_ff, '0, '0, '0);
      end else if (cnt_ff == 4'd3 && buf_ff == atl_pkg::KW_VAR_PACKED) begin
         pend_tok = make_tok(atl_pkg::TOK_VAR, '0, '0, '0, '0);
      end else begin
         pend_tok = make_tok(atl_pkg::TOK_ID, '0, buf_ff, cnt_ff, '0);
      end

      mode_in = mode_ff;
      acc_in  = acc_ff;
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      tok0    = pend_tok;
      tok1    = pend_tok;
      n_wr    = 2'd0;
      flush   = 1'b0;
      own     = 1'b0;
      own_tok = pend_tok;

      if (req_fire && mode_ff != atl_pkg::MODE_HALT) begin
         if (mode_ff == atl_pkg::MODE_NUM && is_digit) begin
            acc_in = (prod[66:63] != 4'd0) ? atl_pkg::NUM_MAX : prod[62:0];
            pos_in = pos_ff + 32'd1;
         end else if (mode_ff == atl_pkg::MODE_IDENT && is_letter) begin
            if (cnt_ff < IDENT_LIMIT) begin
               for (int i = 0; i < 8; i++) begin
                  if (cnt_ff[2:0] == 3'(i)) begin
                     buf_in[8*i +: 8] = c;
                  end
               end
               cnt_in = cnt_ff + 4'd1;
               pos_in = pos_ff + 32'd1;
            end else begin
               // Identifier too long: the pending name is dropped.
               tok0      = make_tok(atl_pkg::TOK_ERROR, '0, '0, '0, pos_ff);
               tok0.last = 1'b1;
               n_wr      = 2'd1;
               mode_in   = atl_pkg::MODE_HALT;
               acc_in    = '0;
               buf_in    = '0;
               cnt_in    = '0;
            end
         end else begin
            flush   = (mode_ff != atl_pkg::MODE_IDLE);
            mode_in = atl_pkg::MODE_IDLE;
            acc_in  = '0;
            buf_in  = '0;
            cnt_in  = '0;
            if (c == atl_pkg::CHAR_EOT) begin
               own     = 1'b1;
               own_tok = make_tok(atl_pkg::TOK_EOF, '0, '0, '0, '0);
               pos_in  = '0;
            end else if (c == atl_pkg::CHAR_SPACE) begin
               pos_in = pos_ff + 32'd1;
            end else if (is_single) begin
               own     = 1'b1;
               own_tok = make_tok(single_kind, '0, '0, '0, '0);
               pos_in  = pos_ff + 32'd1;
            end else if (is_digit) begin
               mode_in = atl_pkg::MODE_NUM;
               acc_in  = atl_pkg::NUM_W'(digit);
               pos_in  = pos_ff + 32'd1;
            end else if (is_letter) begin
               mode_in = atl_pkg::MODE_IDENT;
               buf_in  = atl_pkg::CHARS_W'(c);
               cnt_in  = 4'd1;
               pos_in  = pos_ff + 32'd1;
            end else begin
               own     = 1'b1;
               own_tok = make_tok(atl_pkg::TOK_ERROR, '0, '0, '0, pos_ff);
               mode_in = atl_pkg::MODE_HALT;
            end

            if (flush && own) begin
               tok0      = pend_tok;
               tok1      = own_tok;
               tok1.last = 1'b1;
               n_wr      = 2'd2;
            end else if (flush) begin
               tok0      = pend_tok;
               tok0.last = 1'b1;
               n_wr      = 2'd1;
            end else if (own) begin
               tok0      = own_tok;
               tok0.last = 1'b1;
               n_wr      = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= atl_pkg::MODE_IDLE;
         acc_ff  <= '0;
         buf_ff  <= '0;
         cnt_ff  <= '0;
         pos_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         buf_ff  <= buf_in;
         cnt_ff  <= cnt_in;
         pos_ff  <= pos_in;
      end
   end

   // Queue bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(n_wr);
      rd_ptr_in = rd_ptr_ff + 2'(rsp_fire);
      count_in  = count_ff + 3'(n_wr) - 3'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_wr != 2'd0) begin
         queue_ff[wr_ptr_ff] <= tok0;
      end
      if (n_wr == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= tok1;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {{atl_pkg::PAD_W{1'b0}}, head.position, head.length,
                        head.chars, head.number};

endmodule

`default_nettype wire

/* rtl/core/atl_checker.sv */
// Port-level assertions for the arithmetic token lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module atl_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [167:0] rsp_tdata,
   input wire [3:0]   rsp_tuser,
   input wire         rsp_tlast
);

   // A stalled result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat present right after reset");

   // Eof and error tokens are always the final beat of their byte.
   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == atl_pkg::TOK_EOF || rsp_tuser == atl_pkg::TOK_ERROR)
         |-> rsp_tlast)
      else $error("eof or error token without tlast");

   // Only number tokens carry a value.
   a_number_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != atl_pkg::TOK_NUMBER |-> rsp_tdata[62:0] == 63'd0)
      else $error("non-number token with a nonzero value");

endmodule

bind arith_token_lexer atl_checker u_atl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the arithmetic token lexer with a stream driver and monitor.
`timescale 1ns / 1ps

module tb;
   import atl_pkg::*;

   localparam int IDENT_MAX    = 8;
   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 10;
   localparam int TEXT_BYTES   = 1650;
   localparam int HALT_TAIL    = 40;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SHOW_LIMIT   = 10;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;   // [7:0] char_code
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [DATA_W-1:0]  rsp_tdata;         // number, chars, length, position, zero pad
   logic [3:0]         rsp_tuser;         // [3:0] token_kind
   logic               rsp_tlast;

   arith_token_lexer #(
      .MAX_IDENT_CHARS(IDENT_MAX)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // Scanner state of the predictor.
   scan_mode_type      lex_mode     = MODE_IDLE;
   logic [NUM_W-1:0]   lex_number   = '0;
   logic [CHARS_W-1:0] lex_chars    = '0;
   logic [LEN_W-1:0]   lex_length   = '0;
   logic [POS_W-1:0]   lex_position = '0;

   tok_type    token_q[$];
   logic [7:0] text_q[$];
   string      ops_text = "=+-*/()";
   string      ending;

   int letter_run      = 0;
   int bytes_total     = 0;
   int bytes_sent      = 0;
   int fail_count      = 0;
   int tokens_checked  = 0;
   int eof_count       = 0;
   int keyword_count   = 0;
   int saturated_count = 0;
   int cycle_count     = 0;
   int req_hold        = 0;
   int rsp_hold        = 0;
   bit req_calm        = 1'b0;
   bit rsp_calm        = 1'b0;

   always #(HALF_PERIOD) clock = !clock;

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // Kind of a one-byte token; TOK_ERROR means the byte is not one.
   function automatic token_kind_type punct_kind(logic [7:0] c);
      case (c)
         "=":          return TOK_EQ;
         "+":          return TOK_PLUS;
         "-":          return TOK_MINUS;
         "*":          return TOK_STAR;
         "/":          return TOK_SLASH;
         "(":          return TOK_LPAREN;
         ")":          return TOK_RPAREN;
         CHAR_NEWLINE: return TOK_ENDLINE;
         default:      return TOK_ERROR;
      endcase
   endfunction

   function automatic void emit(token_kind_type kind, logic [NUM_W-1:0] number,
                                logic [CHARS_W-1:0] chars, logic [LEN_W-1:0] length,
                                logic [POS_W-1:0] position);
      tok_type t;
      t.kind     = kind;
      t.number   = number;
      t.chars    = chars;
      t.length   = length;
      t.position = position;
      t.last     = 1'b0;
      token_q.push_back(t);
   endfunction

   function automatic void lex_clear();
      lex_mode   = MODE_IDLE;
      lex_number = '0;
      lex_chars  = '0;
      lex_length = '0;
   endfunction

   function automatic void flush_pending();
      if (lex_mode == MODE_NUM) begin
         emit(TOK_NUMBER, lex_number, '0, '0, '0);
      end else if (lex_mode == MODE_IDENT) begin
         if (lex_length == 3 && lex_chars == KW_VAR_PACKED) begin
            emit(TOK_VAR, '0, '0, '0, '0);
         end else begin
            emit(TOK_ID, '0, lex_chars, lex_length, '0);
         end
      end
      lex_clear();
   endfunction

   // Queues the tokens that one accepted byte must produce.
   function automatic void lex_byte(logic [7:0] c);
      int               queued;
      logic [NUM_W-1:0] digit;
      token_kind_type   kind;
      tok_type          t;
      queued = token_q.size();
      kind   = punct_kind(c);
      digit  = NUM_W'(c - CHAR_ZERO);
      if (lex_mode == MODE_NUM && is_digit(c)) begin
         if (lex_number > (NUM_MAX - digit) / 10) begin
            lex_number = NUM_MAX;
         end else begin
            lex_number = lex_number * 10 + digit;
         end
         lex_position++;
      end else if (lex_mode == MODE_IDENT && is_letter(c)) begin
         if (lex_length < IDENT_MAX) begin
            lex_chars = lex_chars | (CHARS_W'(c) << (8 * lex_length));
            lex_length++;
            lex_position++;
         end else begin
            // The pending identifier is dropped, not emitted.
            lex_clear();
            emit(TOK_ERROR, '0, '0, '0, lex_position);
            lex_mode = MODE_HALT;
         end
      end else if (lex_mode != MODE_HALT) begin
         flush_pending();
         if (c == CHAR_EOT) begin
            emit(TOK_EOF, '0, '0, '0, '0);
            lex_position = '0;
         end else if (c == CHAR_SPACE) begin
            lex_position++;
         end else if (kind != TOK_ERROR) begin
            emit(kind, '0, '0, '0, '0);
            lex_position++;
         end else if (is_digit(c)) begin
            lex_mode   = MODE_NUM;
            lex_number = digit;
            lex_position++;
         end else if (is_letter(c)) begin
            lex_mode   = MODE_IDENT;
            lex_chars  = CHARS_W'(c);
            lex_length = 1;
            lex_position++;
         end else begin
            emit(TOK_ERROR, '0, '0, '0, lex_position);
            lex_mode = MODE_HALT;
         end
      end
      if (token_q.size() > queued) begin
         t      = token_q.pop_back();
         t.last = 1'b1;
         token_q.push_back(t);
      end
   endfunction

   function automatic int pause_cycles(bit calm);
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 1) == 1) begin
         return 8'("a" + $urandom_range(0, 25));
      end
      return 8'("A" + $urandom_range(0, 25));
   endfunction

   // A byte below 128 that the lexer rejects.
   function automatic logic [7:0] bad_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 127));
      end while (is_digit(c) || is_letter(c) || c == CHAR_SPACE || punct_kind(c) != TOK_ERROR);
      return c;
   endfunction

   function automatic void put_char(logic [7:0] c);
      text_q.push_back(c);
      letter_run = is_letter(c) ? letter_run + 1 : 0;
   endfunction

   function automatic void put_text(string s);
      foreach (s[i]) put_char(s[i]);
   endfunction

   function automatic void note_failure(string msg);
      if (fail_count < SHOW_LIMIT) $display("Mismatch: %s", msg);
      fail_count++;
   endfunction

   // Driver: one byte per beat, with a random gap drawn for each byte.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_hold   <= 0;
         lex_clear();
         lex_position = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            lex_byte(req_tdata);
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_hold > 0) begin
               req_tvalid <= 1'b0;
               req_hold   <= req_hold - 1;
            end else if (text_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= text_q.pop_front();
               req_hold   <= pause_cycles(req_calm);
               if ($urandom_range(0, 39) == 0) req_calm <= !req_calm;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each token beat and stalls at random between beats.
   always @(posedge clock) begin : rsp_side
      int      stall;
      tok_type got;
      tok_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got.kind     = token_kind_type'(rsp_tuser);
         got.number   = rsp_tdata[NUM_LSB +: NUM_W];
         got.chars    = rsp_tdata[CHARS_LSB +: CHARS_W];
         got.length   = rsp_tdata[LEN_LSB +: LEN_W];
         got.position = rsp_tdata[POS_LSB +: POS_W];
         got.last     = rsp_tlast;
         if (token_q.size() == 0) begin
            note_failure($sformatf("token of kind %0d with no byte to explain it", rsp_tuser));
         end else begin
            want = token_q.pop_front();
            if (got !== want || rsp_tdata[DATA_W-1 -: PAD_W] !== '0) begin
               note_failure($sformatf({"token %0d expected kind %0d num %0d chars %h len %0d ",
                                       "pos %0d last %b, got kind %0d num %0d chars %h len %0d ",
                                       "pos %0d last %b pad %h"},
                                      tokens_checked, want.kind, want.number, want.chars,
                                      want.length, want.position, want.last, got.kind,
                                      got.number, got.chars, got.length, got.position,
                                      got.last, rsp_tdata[DATA_W-1 -: PAD_W]));
            end
         end
         tokens_checked++;
         if (got.kind == TOK_EOF) eof_count++;
         if (got.kind == TOK_VAR) keyword_count++;
         if (got.kind == TOK_NUMBER && got.number == NUM_MAX) saturated_count++;
         stall = pause_cycles(rsp_calm);
         rsp_tready <= (stall == 0);
         rsp_hold   <= (stall == 0) ? 0 : stall - 1;
         if ($urandom_range(0, 39) == 0) rsp_calm <= !rsp_calm;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out with %0d of %0d bytes sent and %0d tokens outstanding",
                  bytes_sent, bytes_total, token_q.size());
         $display("FAIL arith_token_lexer");
         $finish;
      end
   end

   initial begin
      int len;
      // Directed text: every token kind but the error token, a keyword, adjacency without spaces,
      // and an identifier still pending when the text ends.
      put_text("var =Zz9+(y)*/-\nab");
      put_char(CHAR_EOT);

      while (text_q.size() < TEXT_BYTES) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
               if ($urandom_range(0, 19) == 0) begin
                  // Largest value, and one past it, which saturates.
                  put_text($urandom_range(0, 1) ? "9223372036854775807" : "9223372036854775808");
               end else begin
                  len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 4);
                  repeat (len) put_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
               end
            end
            5, 6, 7, 8, 9: begin
               if (letter_run > 0) put_char(CHAR_SPACE);
               case ($urandom_range(0, 9))
                  0, 1: put_text("var");
                  2:    put_text("va");
                  3:    put_text("vars");
                  4:    put_text("Var");
                  default: begin
                     len = ($urandom_range(0, 4) == 0) ? IDENT_MAX : $urandom_range(1, IDENT_MAX);
                     repeat (len) put_char(rand_letter());
                  end
               endcase
            end
            10, 11, 12, 13, 14, 15: put_char(ops_text[$urandom_range(0, 6)]);
            16, 17: repeat ($urandom_range(1, 2)) put_char(CHAR_SPACE);
            18: put_char(CHAR_NEWLINE);
            default: begin
               if ($urandom_range(0, 1) == 1) put_char(CHAR_EOT);
               else put_char(CHAR_NEWLINE);
            end
         endcase
      end

      // The run ends in a halt, since only reset leaves that state.
      case ($urandom_range(0, 4))
         0: begin
            ending = "an overlong identifier";
            if (letter_run > 0) put_char(CHAR_SPACE);
            repeat (IDENT_MAX + 1) put_char(rand_letter());
         end
         1: begin
            ending = "a bad byte right after a number";
            put_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
            put_char(bad_byte());
         end
         2: begin
            ending = "a bad byte right after an identifier";
            // A fresh one-letter name, so it cannot grow past the limit.
            if (letter_run > 0) put_char(CHAR_SPACE);
            put_char(rand_letter());
            put_char(bad_byte());
         end
         3: begin
            ending = "a bad byte below 128";
            put_char(CHAR_SPACE);
            put_char(bad_byte());
         end
         default: begin
            ending = "a byte above 127";
            put_char(CHAR_SPACE);
            put_char(8'($urandom_range(128, 255)));
         end
      endcase
      repeat (HALT_TAIL) put_char(8'($urandom_range(0, 255)));
      bytes_total = text_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (bytes_sent < bytes_total) @(posedge clock);
      while (token_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Lexed %0d bytes ending %0d texts; checked %0d tokens, %0d keywords, %0d saturated.",
               bytes_total, eof_count, tokens_checked, keyword_count, saturated_count);
      $display("The lexer halted on %s and swallowed %0d more bytes.", ending, HALT_TAIL);
      if (fail_count == 0) begin
         $display("PASS arith_token_lexer");
      end else begin
         $display("%0d mismatches in total", fail_count);
         $display("FAIL arith_token_lexer");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/atl_pkg.sv
rtl/core/arith_token_lexer.sv
rtl/core/atl_checker.sv
dv/tb.sv
